/* rtl/tbpr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbpr_pkg: shared types and constants
// word formats, register indexes and the colour-to-grey table used by the
// tile background renderer and its video memory.
// ----------------------------------------------------------------------------
package tbpr_pkg;

	localparam int VRAM_BYTES = 8192;
	localparam int VRAM_AW    = 13;

	// op field codes
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_RENDER = 1'b1;

	// configuration register indexes
	localparam logic [1:0] REG_LCD_CONTROL = 2'd0;
	localparam logic [1:0] REG_SCROLL_Y    = 2'd1;
	localparam logic [1:0] REG_SCROLL_X    = 2'd2;

	localparam logic [7:0] LCD_CONTROL_RESET = 8'h91;

	// lcd_control bit positions
	localparam int LCDC_DISPLAY_EN = 7;
	localparam int LCDC_DATA_AREA  = 4;
	localparam int LCDC_MAP_SEL    = 3;
	localparam int LCDC_BG_EN      = 0;

	// tile map areas, as offsets from the start of video memory
	localparam logic [VRAM_AW-1:0] MAP_LOW_BASE  = 13'h1800;
	localparam logic [VRAM_AW-1:0] MAP_HIGH_BASE = 13'h1C00;
	// signed tile data area
	localparam logic [VRAM_AW-1:0] SIGNED_BASE   = 13'h0800;
	localparam logic [7:0]         SIGNED_BIAS   = 8'h80;

	typedef struct packed {
		logic       op;
		logic [12:0] address;
		logic [7:0] write_data;
		logic [7:0] screen_line;
		logic [7:0] screen_column;
	} in_word_t;

	typedef struct packed {
		logic [7:0] shade;
		logic [1:0] colour_index;
	} out_word_t;

	typedef struct packed {
		logic               en;
		logic               we;
		logic [VRAM_AW-1:0] addr;
		logic [7:0]         wdata;
	} vram_req_t;

	// grey level is (3 - colour) * 85
	function automatic logic [7:0] shade_of(input logic [1:0] colour);
		logic [7:0] s;
		case (colour)
			2'd0: s = 8'd255;
			2'd1: s = 8'd170;
			2'd2: s = 8'd85;
			2'd3: s = 8'd0;
			default: s = 8'd0;
		endcase
		return s;
	endfunction

endpackage

/* rtl/tbpr_vram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbpr_vram: video memory
// single-port synchronous byte memory, one access a cycle, registered read.
// ----------------------------------------------------------------------------
module tbpr_vram (
	input  logic                clk,
	input  tbpr_pkg::vram_req_t req,
	output logic [7:0]          rdata
);

	logic [7:0] mem [tbpr_pkg::VRAM_BYTES];
	logic [7:0] rdata_q;

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (req.en) begin
			if (req.we) begin
				mem[req.addr] <= req.wdata;
			end else begin
				rdata_q <= mem[req.addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/tile_background_pixel_renderer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_background_pixel_renderer: tile map background pixel renderer
// stores bytes into an 8 KiB video memory and renders background pixels
// through the tile map and tile data held in it.
// ----------------------------------------------------------------------------
// usage
//   input words (in_valid/in_ready) either write one video memory byte or
//   ask for the background pixel at a screen line and column. a pixel word
//   comes out on out_valid/out_ready; writes and pixels that are off screen
//   or blanked by lcd_control give no word.
//   config writes (cfg_valid/cfg_ready, cfg_index 0..2) set lcd_control,
//   scroll_y and scroll_x; index 3 is ignored. cfg_ready is always high.
//   writes go in every cycle while no pixel is reading video memory. a pixel
//   uses the single video memory port for its map byte, low plane and high
//   plane in that order, and in_ready stays low during the plane reads; the
//   next item can be taken as the finished pixel moves to the output register.
//   the output register frees the input side: while a word waits there the
//   next item is still taken; when a finished pixel finds the output
//   register full, the block holds it and keeps in_ready low.
//   reset sets lcd_control to 0x91 and the scrolls to 0 and empties the
//   pipeline; video memory is not cleared and must be written before use.
// ----------------------------------------------------------------------------
module tile_background_pixel_renderer #(
	parameter int SCREEN_COLUMNS = 160,
	parameter int SCREEN_LINES   = 144
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  tbpr_pkg::in_word_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output tbpr_pkg::out_word_t  out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [7:0]           cfg_data
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_LO,
		PH_HI,
		PH_FIN
	} phase_t;

	phase_t              phase_q;
	logic [7:0]          lcdc_q;
	logic [7:0]          scroll_y_q;
	logic [7:0]          scroll_x_q;
	logic [2:0]          row_q;
	logic [2:0]          bit_q;
	logic                area_q;
	logic [11:0]         daddr_q;
	logic                lo_bit_q;
	tbpr_pkg::out_word_t out_q;
	logic                out_valid_q;

	tbpr_pkg::vram_req_t req;
	logic [7:0]          rdata;

	logic                accept;
	logic                start;
	logic                slot_free;
	logic                shows;
	logic [7:0]          line_scr;
	logic [7:0]          pos_scr;
	logic [tbpr_pkg::VRAM_AW-1:0] map_addr;
	logic [tbpr_pkg::VRAM_AW-1:0] data_addr;
	logic [1:0]          colour;

	assign cfg_ready = 1'b1;
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (phase_q == PH_IDLE) || ((phase_q == PH_FIN) && slot_free);
	assign accept    = in_valid && in_ready;

	assign line_scr = in_data.screen_line + scroll_y_q;
	assign pos_scr  = in_data.screen_column + scroll_x_q;

	assign shows = lcdc_q[tbpr_pkg::LCDC_DISPLAY_EN] && lcdc_q[tbpr_pkg::LCDC_BG_EN]
		&& ({1'b0, in_data.screen_line} < 9'(SCREEN_LINES))
		&& ({1'b0, in_data.screen_column} < 9'(SCREEN_COLUMNS));

	assign start = accept && (in_data.op == tbpr_pkg::OP_RENDER) && shows;

	// map entry: base + line/8 * 32 + column/8
	assign map_addr = (lcdc_q[tbpr_pkg::LCDC_MAP_SEL] ? tbpr_pkg::MAP_HIGH_BASE
		: tbpr_pkg::MAP_LOW_BASE) | {3'b000, line_scr[7:3], pos_scr[7:3]};

	// tile row address from the map byte now in rdata
	always_comb begin
		if (area_q) begin
			data_addr = {1'b0, rdata, row_q, 1'b0};
		end else begin
			data_addr = tbpr_pkg::SIGNED_BASE
				+ {1'b0, rdata ^ tbpr_pkg::SIGNED_BIAS, row_q, 1'b0};
		end
	end

	always_comb begin
		req       = '0;
		req.wdata = in_data.write_data;
		case (phase_q)
			PH_LO: begin
				req.en   = 1'b1;
				req.addr = data_addr;
			end
			PH_HI: begin
				req.en   = 1'b1;
				req.addr = {daddr_q, 1'b1};
			end
			default: begin
				req.en   = accept;
				req.we   = (in_data.op == tbpr_pkg::OP_WRITE);
				req.addr = (in_data.op == tbpr_pkg::OP_WRITE) ? in_data.address : map_addr;
			end
		endcase
	end

	tbpr_vram u_vram (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	// bit 7 of a plane byte is the leftmost pixel
	assign colour = {rdata[~bit_q], lo_bit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcdc_q     <= tbpr_pkg::LCD_CONTROL_RESET;
			scroll_y_q <= 8'd0;
			scroll_x_q <= 8'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				tbpr_pkg::REG_LCD_CONTROL: lcdc_q     <= cfg_data;
				tbpr_pkg::REG_SCROLL_Y:    scroll_y_q <= cfg_data;
				tbpr_pkg::REG_SCROLL_X:    scroll_x_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (phase_q)
				PH_LO: phase_q <= PH_HI;
				PH_HI: phase_q <= PH_FIN;
				PH_FIN: begin
					if (slot_free) begin
						phase_q <= start ? PH_LO : PH_IDLE;
					end
				end
				default: phase_q <= start ? PH_LO : PH_IDLE;
			endcase
			// a finished pixel refills the slot in the cycle it drains
			if ((phase_q == PH_FIN) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item context and plane data
	always_ff @(posedge clk) begin
		if (accept) begin
			row_q  <= line_scr[2:0];
			bit_q  <= pos_scr[2:0];
			area_q <= lcdc_q[tbpr_pkg::LCDC_DATA_AREA];
		end
		if (phase_q == PH_LO) begin
			daddr_q <= data_addr[tbpr_pkg::VRAM_AW-1:1];
		end
		if (phase_q == PH_HI) begin
			lo_bit_q <= rdata[~bit_q];
		end
		if ((phase_q == PH_FIN) && slot_free) begin
			out_q.colour_index <= colour;
			out_q.shade        <= tbpr_pkg::shade_of(colour);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* rtl/tbpr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbpr_checker: port checks for the tile background renderer
// watches the top-level ports and is bound to every instance.
// ----------------------------------------------------------------------------
module tbpr_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input tbpr_pkg::in_word_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input tbpr_pkg::out_word_t out_data,
	input logic                cfg_valid,
	input logic                cfg_ready
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// grey level always follows the colour
	a_shade: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.shade == tbpr_pkg::shade_of(out_data.colour_index))
		else $error("shade does not match colour");

	// config writes are never refused
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

	// a video memory write never holds off the next word
	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.op == tbpr_pkg::OP_WRITE |=> in_ready)
		else $error("input stalled after a write");

endmodule

bind tile_background_pixel_renderer tbpr_checker u_tbpr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);
